>>> rtl/sfcd_pkg.sv
// ----------------------------------------------------------------------------
// sfcd_pkg: shared types and constants of the sync frame deframer
// Window geometry, sync bytes and checksum widths used by the cell, match and top modules.
// ----------------------------------------------------------------------------
package sfcd_pkg;

	localparam int unsigned WinLen  = 10;
	localparam int unsigned SumLen  = 8;
	localparam int unsigned ByteW   = 8;
	localparam int unsigned SumW    = 11;
	localparam int unsigned CheckW  = 16;

	typedef logic [ByteW-1:0] byte_t;
	typedef logic [SumW-1:0]  sum_t;
	typedef byte_t [WinLen-1:0] win_t;

	localparam byte_t SyncHi = 8'h5E;
	localparam byte_t SyncLo = 8'h0C;

	localparam int unsigned PosVehicle = 2;
	localparam int unsigned PosCommand = 3;
	localparam int unsigned PosHeading = 4;
	localparam int unsigned PosCheckHi = 8;
	localparam int unsigned PosCheckLo = 9;

	typedef struct packed {
		logic  hit;
		byte_t vehicle_id;
		byte_t heading;
	} match_t;

endpackage

>>> rtl/sfcd_cell.sv
// ----------------------------------------------------------------------------
// sfcd_cell: one byte slot of the sliding window
// Holds one byte, takes its neighbour's byte on each shift and adds its
// byte to the running checksum passed along the row.
// ----------------------------------------------------------------------------
module sfcd_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               shift,
	input  sfcd_pkg::byte_t    byte_in,
	input  sfcd_pkg::sum_t     sum_in,
	output sfcd_pkg::byte_t    byte_out,
	output sfcd_pkg::sum_t     sum_out
);

	sfcd_pkg::byte_t byte_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else if (shift) begin
			byte_q <= byte_in;
		end
	end

	assign byte_out = byte_q;
	assign sum_out  = sum_in + sfcd_pkg::sum_t'(byte_q);

endmodule

>>> rtl/sfcd_match.sv
// ----------------------------------------------------------------------------
// sfcd_match: frame test on the current window
// Checks the sync bytes, the additive checksum and the reply command and
// picks out the vehicle id and heading.
// ----------------------------------------------------------------------------
module sfcd_match (
	input  sfcd_pkg::win_t     win,
	input  sfcd_pkg::sum_t     sum,
	input  sfcd_pkg::byte_t    reply_command,
	output sfcd_pkg::match_t   result
);

	logic                          sync_ok;
	logic                          check_ok;
	logic [sfcd_pkg::CheckW-1:0]   want;

	assign want     = {win[sfcd_pkg::PosCheckHi], win[sfcd_pkg::PosCheckLo]};
	assign sync_ok  = (win[0] == sfcd_pkg::SyncHi) && (win[1] == sfcd_pkg::SyncLo);
	assign check_ok = (sfcd_pkg::CheckW'(sum) == want);

	always_comb begin
		result.hit        = sync_ok && check_ok &&
		                    (win[sfcd_pkg::PosCommand] == reply_command);
		result.vehicle_id = win[sfcd_pkg::PosVehicle];
		result.heading    = win[sfcd_pkg::PosHeading];
	end

endmodule

>>> rtl/sync_frame_checksum_deframer_top.sv
// ----------------------------------------------------------------------------
// sync_frame_checksum_deframer_top: sync-word frame finder with checksum
// Shifts received bytes through a row of ten cells and reports reply frames.
//
// Usage:
//   Input channel (in_valid, in_ready, rx_byte): one received byte per
//   request. Output channel (out_valid, out_ready, vehicle_id, heading): one
//   request per reply frame found. Configuration channel (cfg_valid,
//   cfg_ready, reply_command) sets the command byte; cfg_ready is always high.
//   A frame completed by an accepted byte is tested on the shifted window
//   and loaded into the output register once the output slot is free.
//   Throughput: one byte per cycle while the receiver takes results; the
//   window test is an eight-cell checksum chain and the sync, checksum and command compares, each cycle.
//   Reset clears the window to zeros, the command register to zero and all
//   pending results; no frame is seen before ten bytes have arrived.
//   When the receiver stalls with a result waiting, one more byte is taken
//   and tested; further bytes are held off until the result is taken.
// ----------------------------------------------------------------------------
module sync_frame_checksum_deframer_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         rx_byte,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         vehicle_id,
	output logic [7:0]         heading,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [7:0]         reply_command
);

	sfcd_pkg::win_t                     win;
	sfcd_pkg::sum_t [sfcd_pkg::WinLen:0] sum_chain;
	sfcd_pkg::byte_t                    reply_command_q;
	sfcd_pkg::match_t                   match;
	logic                               in_accept;
	logic                               can_advance;
	logic                               pend_s1;
	logic                               out_valid_q;
	sfcd_pkg::byte_t                    vehicle_id_q;
	sfcd_pkg::byte_t                    heading_q;

	assign cfg_ready   = 1'b1;
	assign can_advance = !out_valid_q || out_ready;
	assign in_ready    = !pend_s1 || can_advance;
	assign in_accept   = in_valid && in_ready;

	assign sum_chain[0] = '0;

	for (genvar i = 0; i < sfcd_pkg::WinLen; i++) begin : g_cell
		sfcd_pkg::byte_t next_byte;
		if (i == sfcd_pkg::WinLen - 1) begin : g_head
			assign next_byte = rx_byte;
		end else begin : g_body
			assign next_byte = win[i+1];
		end
		sfcd_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift    (in_accept),
			.byte_in  (next_byte),
			.sum_in   (sum_chain[i]),
			.byte_out (win[i]),
			.sum_out  (sum_chain[i+1])
		);
	end

	sfcd_match u_match (
		.win           (win),
		.sum           (sum_chain[sfcd_pkg::SumLen]),
		.reply_command (reply_command_q),
		.result        (match)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reply_command_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			reply_command_q <= reply_command;
		end
	end

	// hold the fresh window until the output slot is free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_accept) begin
				pend_s1 <= 1'b1;
			end else if (can_advance) begin
				pend_s1 <= 1'b0;
			end
			if (pend_s1 && can_advance) begin
				out_valid_q <= match.hit;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pend_s1 && can_advance && match.hit) begin
			vehicle_id_q <= match.vehicle_id;
			heading_q    <= match.heading;
		end
	end

	assign out_valid  = out_valid_q;
	assign vehicle_id = vehicle_id_q;
	assign heading    = heading_q;

endmodule

>>> rtl/sfcd_checker.sv
// ----------------------------------------------------------------------------
// sfcd_checker: port-level checks of the deframer
// Watches the top-level ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
module sfcd_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [7:0] vehicle_id,
	input  logic [7:0] heading,
	input  logic       cfg_ready
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(vehicle_id) && $stable(heading))
		else $error("result request changed while stalled");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result request without a byte taken two cycles before");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input held off with an empty output");

	a_cfg_open: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration port closed");

endmodule

bind sync_frame_checksum_deframer_top sfcd_checker u_sfcd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.vehicle_id (vehicle_id),
	.heading    (heading),
	.cfg_ready  (cfg_ready)
);
